@@ hdl/evr_pkg.sv @@
// evr_pkg: shared types and constants for the edge vertex relabel block
// holds field widths, controller states and the command/status structs
// no dependencies
package evr_pkg;

   // fixed field widths of the request and response
   localparam int VERTEX_W = 32;
   localparam int OUT_W    = 11;

   // response status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   // controller states, one-hot
   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SCAN   = 6'b000010,
      ST_DECIDE = 6'b000100,
      ST_INS_A  = 6'b001000,
      ST_INS_B  = 6'b010000,
      ST_RESP   = 6'b100000
   } evr_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;       // capture request keys and start the table scan
      logic ins_a;      // insert first key if not found
      logic ins_b;      // insert second key if not found
      logic load_rsp;   // load the response register
      logic rsp_full;   // response reports a rejected edge
   } evr_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic self_loop;  // raw ids of the offered request are equal
      logic scan_done;  // table scan finished
      logic full;       // new keys do not fit in the table
      logic out_free;   // response register can take a new value
   } evr_status_type;

endpackage

@@ hdl/evr_channels.sv @@
// evr_req_if, evr_rsp_if: valid/ready channels of the edge vertex relabel block
// depends on evr_pkg for field widths
interface evr_req_if;
   import evr_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [VERTEX_W-1:0] first_vertex;
   logic signed [VERTEX_W-1:0] second_vertex;

   modport source (output valid, output first_vertex, output second_vertex, input ready);
   modport sink   (input valid, input first_vertex, input second_vertex, output ready);
endinterface

interface evr_rsp_if;
   import evr_pkg::*;

   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] low_id;
   logic [OUT_W-1:0] high_id;
   logic             status;
   logic [OUT_W-1:0] node_count;

   modport source (output valid, output low_id, output high_id, output status,
                   output node_count, input ready);
   modport sink   (input valid, input low_id, input high_id, input status,
                   input node_count, output ready);
endinterface

@@ hdl/evr_ctrl.sv @@
// evr_ctrl: sequencing state machine of the edge vertex relabel block
// depends on evr_pkg for states and the command/status structs
module evr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  evr_pkg::evr_status_type sts,
   output evr_pkg::evr_cmd_type    cmd
);
   import evr_pkg::*;

   evr_state_type state_ff, state_in;
   logic          reject_ff, reject_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         reject_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         reject_ff <= reject_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      reject_in = reject_ff;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            // a self-loop is taken and dropped here
            if (req_valid && !sts.self_loop) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.scan_done) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            reject_in = sts.full;
            state_in  = sts.full ? ST_RESP : ST_INS_A;
         end
         ST_INS_A: begin
            cmd.ins_a = 1'b1;
            state_in  = ST_INS_B;
         end
         ST_INS_B: begin
            cmd.ins_b = 1'b1;
            state_in  = ST_RESP;
         end
         ST_RESP: begin
            cmd.rsp_full = reject_ff;
            if (sts.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ hdl/evr_datapath.sv @@
// evr_datapath: key table, scan pipeline, insert logic and response register
// depends on evr_pkg; driven by evr_ctrl through the command/status structs
module evr_datapath #(
   parameter int TABLE_DEPTH = 1024,
   parameter int KEY_WIDTH   = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic signed [evr_pkg::VERTEX_W-1:0]  req_first_vertex,
   input  logic signed [evr_pkg::VERTEX_W-1:0]  req_second_vertex,
   input  evr_pkg::evr_cmd_type                 cmd,
   output evr_pkg::evr_status_type              sts,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [evr_pkg::OUT_W-1:0]            rsp_low_id,
   output logic [evr_pkg::OUT_W-1:0]            rsp_high_id,
   output logic                                 rsp_status,
   output logic [evr_pkg::OUT_W-1:0]            rsp_node_count
);
   import evr_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   logic [KEY_WIDTH-1:0] key_mem [TABLE_DEPTH];

   logic [KEY_WIDTH-1:0] key_a_ff, key_b_ff;
   logic [KEY_WIDTH-1:0] new_key_a, new_key_b;
   logic [63:0]          ext_a, ext_b;
   logic [CW-1:0]        count_ff;
   logic [CW-1:0]        id_a_ff, id_b_ff;
   logic [CW-1:0]        issue_idx_ff, pend_idx_ff;
   logic                 pend_valid_ff;
   logic                 issue_en;
   logic [KEY_WIDTH-1:0] rd_data_ff;
   logic [1:0]           need;
   logic [CW:0]          total;
   logic                 same_key;
   logic [CW-1:0]        low_sel, high_sel;
   logic                 rsp_valid_ff;
   logic [OUT_W-1:0]     rsp_low_ff, rsp_high_ff, rsp_count_ff;
   logic                 rsp_status_ff;

   // raw id sign-extended then cut to the key width
   assign ext_a     = 64'(req_first_vertex);
   assign ext_b     = 64'(req_second_vertex);
   assign new_key_a = ext_a[KEY_WIDTH-1:0];
   assign new_key_b = ext_b[KEY_WIDTH-1:0];

   assign same_key = (key_a_ff == key_b_ff);
   assign issue_en = (issue_idx_ff < count_ff);

   // table memory: one write port, one registered read port for the scan
   always_ff @(posedge clock) begin
      if (cmd.ins_a && id_a_ff == '0) begin
         key_mem[count_ff[AW-1:0]] <= key_a_ff;
      end else if (cmd.ins_b && id_b_ff == '0 && !same_key) begin
         key_mem[count_ff[AW-1:0]] <= key_b_ff;
      end
      if (issue_en) rd_data_ff <= key_mem[issue_idx_ff[AW-1:0]];
   end

   // scan control: issue one read a cycle, compare in the next cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= issue_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         issue_idx_ff <= '0;
      end else if (issue_en) begin
         issue_idx_ff <= issue_idx_ff + 1'b1;
      end
      pend_idx_ff <= issue_idx_ff;
   end

   // keys and found ids of the request in progress
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_a_ff <= new_key_a;
         key_b_ff <= new_key_b;
         id_a_ff  <= '0;
         id_b_ff  <= '0;
      end else if (cmd.ins_a) begin
         if (id_a_ff == '0) id_a_ff <= count_ff + 1'b1;
      end else if (cmd.ins_b) begin
         if (id_b_ff == '0) id_b_ff <= same_key ? id_a_ff : count_ff + 1'b1;
      end else if (pend_valid_ff) begin
         if (id_a_ff == '0 && rd_data_ff == key_a_ff) id_a_ff <= pend_idx_ff + 1'b1;
         if (id_b_ff == '0 && rd_data_ff == key_b_ff) id_b_ff <= pend_idx_ff + 1'b1;
      end
   end

   // number of stored keys
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.ins_a && id_a_ff == '0) begin
         count_ff <= count_ff + 1'b1;
      end else if (cmd.ins_b && id_b_ff == '0 && !same_key) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   // room check for the new keys of the edge
   assign need  = {1'b0, id_a_ff == '0} + {1'b0, id_b_ff == '0 && !same_key};
   assign total = {1'b0, count_ff} + (CW+1)'(need);

   assign low_sel  = (id_a_ff < id_b_ff) ? id_a_ff : id_b_ff;
   assign high_sel = (id_a_ff < id_b_ff) ? id_b_ff : id_a_ff;

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_low_ff    <= cmd.rsp_full ? '0 : OUT_W'(low_sel);
         rsp_high_ff   <= cmd.rsp_full ? '0 : OUT_W'(high_sel);
         rsp_status_ff <= cmd.rsp_full ? STATUS_FULL : STATUS_OK;
         rsp_count_ff  <= OUT_W'(count_ff);
      end
   end

   assign sts.self_loop = (req_first_vertex == req_second_vertex);
   assign sts.scan_done = !issue_en && !pend_valid_ff;
   assign sts.full      = (total > (CW+1)'(TABLE_DEPTH));
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_low_id     = rsp_low_ff;
   assign rsp_high_id    = rsp_high_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_node_count = rsp_count_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (count_ff == $past(count_ff) || count_ff == $past(count_ff) + 1'b1))
      else $error("entry count moved by more than one");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> sts.out_free)
      else $error("response loaded over an untaken response");

   a_ids_ordered: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp && !cmd.rsp_full |=> rsp_low_ff <= rsp_high_ff && rsp_low_ff != '0)
      else $error("relabelled ids out of order or missing");
`endif

endmodule

@@ hdl/edge_vertex_relabel.sv @@
// edge_vertex_relabel: top level, first-seen dense id assignment for graph edges
// depends on evr_pkg, evr_channels, evr_ctrl and evr_datapath
//
//   channel   dir   payload                                  handshake
//   req_ch    in    first_vertex, second_vertex              valid/ready
//   rsp_ch    out   low_id, high_id, status, node_count      valid/ready
//
// one request is in flight at a time: the next request is taken only after the table
// scan, the inserts (none for a rejected edge) and the loading of the response: the
// key table is one memory searched linearly, one stored key per cycle, both
// endpoints compared at once
// reset (synchronous) empties the table by clearing the entry count; no sweep
// the response sits in an output register, so the next request is taken while an
// earlier response waits; a new response stalls until the waiting one is taken
// a self-loop is taken and dropped in the idle state and gives no response
module edge_vertex_relabel #(
   parameter int TABLE_DEPTH = 1024,
   parameter int KEY_WIDTH   = 32
) (
   input  logic      clock,
   input  logic      reset,
   evr_req_if.sink   req_ch,
   evr_rsp_if.source rsp_ch
);
   import evr_pkg::*;

   evr_cmd_type    cmd;
   evr_status_type sts;

   // sequencing
   evr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // table and response datapath
   evr_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_WIDTH   (KEY_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_first_vertex  (req_ch.first_vertex),
      .req_second_vertex (req_ch.second_vertex),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_low_id        (rsp_ch.low_id),
      .rsp_high_id       (rsp_ch.high_id),
      .rsp_status        (rsp_ch.status),
      .rsp_node_count    (rsp_ch.node_count)
   );

endmodule

@@ sim/tb_top.sv @@
// tb_top: self-checking bench for edge_vertex_relabel, random and directed edge requests
// depends on evr_pkg and evr_channels; a tracker class predicts each dense id response
module tb_top;
   import evr_pkg::*;

   localparam int TB_DEPTH     = 1024;
   localparam int TB_KEY_W     = 32;
   localparam int STAGE1_ITEMS = 1100;
   localparam int STAGE3_ITEMS = 80;
   localparam int PHASE_LEN    = 50;
   localparam int LIMIT_CYCLES = 8000000;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   // dense id tracker: mirrors the key table and queues predicted responses
   class dense_id_tracker #(int DEPTH = 1024, int KEY_W = 32);
      typedef struct {
         logic [OUT_W-1:0] low_id;
         logic [OUT_W-1:0] high_id;
         logic             status;
         logic [OUT_W-1:0] node_count;
      } relabel_type;

      int unsigned         dense_id [logic [63:0]];
      logic [VERTEX_W-1:0] seen_raw [$];
      int unsigned         node_total;
      relabel_type         pending_ids [$];
      int                  errors;

      function new();
         node_total = 0;
         errors     = 0;
      endfunction

      // sign-extend the raw id, then keep the low key bits
      function logic [63:0] key_of(logic [VERTEX_W-1:0] raw);
         logic [63:0] wide;
         wide = {{(64-VERTEX_W){raw[VERTEX_W-1]}}, raw};
         if (KEY_W >= 64) return wide;
         return wide & ((64'd1 << KEY_W) - 64'd1);
      endfunction

      function bit is_known(logic [VERTEX_W-1:0] raw);
         return dense_id.exists(key_of(raw));
      endfunction

      function int unsigned lookup_or_add(logic [63:0] key, logic [VERTEX_W-1:0] raw);
         if (dense_id.exists(key)) return dense_id[key];
         node_total++;
         dense_id[key] = node_total;
         seen_raw.insert(seen_raw.size(), raw);
         return node_total;
      endfunction

      // predict the response to one accepted edge request
      function void note_edge(logic [VERTEX_W-1:0] a, logic [VERTEX_W-1:0] b);
         logic [63:0] ka, kb;
         int unsigned need, ida, idb;
         relabel_type res;
         // self-loop: nothing comes back
         if (a == b) return;
         ka   = key_of(a);
         kb   = key_of(b);
         need = 0;
         if (!dense_id.exists(ka)) need++;
         if (!dense_id.exists(kb) && kb != ka) need++;
         if (node_total + need > DEPTH) begin
            // table full: whole edge rejected, nothing stored
            res.low_id  = '0;
            res.high_id = '0;
            res.status  = STATUS_FULL;
         end else begin
            ida = lookup_or_add(ka, a);
            idb = lookup_or_add(kb, b);
            res.low_id  = OUT_W'((ida < idb) ? ida : idb);
            res.high_id = OUT_W'((ida < idb) ? idb : ida);
            res.status  = STATUS_OK;
         end
         res.node_count = OUT_W'(node_total);
         pending_ids.insert(pending_ids.size(), res);
      endfunction

      task report_mismatch(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      // compare one accepted response with the oldest prediction
      task check_relabel(logic [OUT_W-1:0] low, logic [OUT_W-1:0] high, logic status,
                         logic [OUT_W-1:0] count);
         relabel_type want;
         if (pending_ids.size() == 0) begin
            report_mismatch($sformatf("response low %0d high %0d status %0b count %0d unexpected",
                                      low, high, status, count));
            return;
         end
         want = pending_ids.pop_front();
         if (low !== want.low_id)
            report_mismatch($sformatf("low_id got %0d expected %0d", low, want.low_id));
         if (high !== want.high_id)
            report_mismatch($sformatf("high_id got %0d expected %0d", high, want.high_id));
         if (status !== want.status)
            report_mismatch($sformatf("status got %0b expected %0b", status, want.status));
         if (count !== want.node_count)
            report_mismatch($sformatf("node_count got %0d expected %0d", count, want.node_count));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   int   cycles = 0;
   int   item_idx = 0;
   int   recv_stall_pct = 0;

   dense_id_tracker #(TB_DEPTH, TB_KEY_W) sb;

   evr_req_if req_ch ();
   evr_rsp_if rsp_ch ();

   edge_vertex_relabel #(
      .TABLE_DEPTH(TB_DEPTH),
      .KEY_WIDTH  (TB_KEY_W)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   // clock, period 20
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // response side back-pressure
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // response check on each accepted response
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_relabel(rsp_ch.low_id, rsp_ch.high_id, rsp_ch.status, rsp_ch.node_count);
   end

   // drive one edge request, idling as the current phase asks
   task automatic send_edge(input logic [VERTEX_W-1:0] a, input logic [VERTEX_W-1:0] b);
      int idle_pct;
      case (idle_mode_type'((item_idx / PHASE_LEN) % 4))
         IDLE_NONE: begin
            idle_pct = 0;  recv_stall_pct = 0;
         end
         IDLE_SENDER: begin
            idle_pct = 58; recv_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            idle_pct = 0;  recv_stall_pct = 58;
         end
         default: begin
            idle_pct = 17; recv_stall_pct = 17;
         end
      endcase
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.first_vertex  <= a;
      req_ch.second_vertex <= b;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_edge(a, b);
      item_idx++;
   endtask

   function automatic logic [VERTEX_W-1:0] fresh_vertex();
      logic [VERTEX_W-1:0] v;
      do v = $urandom; while (sb.is_known(v));
      return v;
   endfunction

   function automatic logic [VERTEX_W-1:0] known_vertex();
      if (sb.seen_raw.size() == 0) return fresh_vertex();
      return sb.seen_raw[$urandom_range(sb.seen_raw.size() - 1)];
   endfunction

   // one random edge; weights in percent, the rest joins two stored vertices (two fresh ones while fewer are stored)
   task automatic random_edge(input int w_self, input int w_noise, input int w_one,
                              input int w_two);
      int                  r;
      logic [VERTEX_W-1:0] a, b;
      r = $urandom_range(99);
      if (r < w_self) begin
         a = $urandom_range(1) ? known_vertex() : VERTEX_W'($urandom);
         b = a;
      end else if (r < w_self + w_noise) begin
         a = $urandom;
         b = $urandom;
      end else if (r < w_self + w_noise + w_one) begin
         a = known_vertex();
         b = fresh_vertex();
         if ($urandom_range(1)) begin
            a = b;
            b = known_vertex();
         end
      end else if (r < w_self + w_noise + w_one + w_two || sb.seen_raw.size() < 2) begin
         a = fresh_vertex();
         b = fresh_vertex();
      end else begin
         a = known_vertex();
         b = known_vertex();
      end
      send_edge(a, b);
   endtask

   initial begin
      sb = new();
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.first_vertex  = '0;
      req_ch.second_vertex = '0;
      rsp_ch.ready         = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, both new, reversed order, self-loops, one endpoint new
      send_edge(32'h8000_0000, 32'h7FFF_FFFF);
      send_edge(32'h7FFF_FFFF, 32'h8000_0000);
      send_edge(32'h0000_0000, 32'hFFFF_FFFF);
      send_edge(32'hFFFF_FFFF, 32'h0000_0000);
      send_edge(32'h0000_0005, 32'h0000_0005);
      send_edge(32'h8000_0000, 32'h8000_0000);
      send_edge(32'h0000_0000, 32'h7FFF_FFFF);
      send_edge(32'h5555_5555, 32'hFFFF_FFFF);
      send_edge(32'h8000_0000, 32'hAAAA_AAAA);
      send_edge(32'h0000_0001, 32'hFFFF_FFFE);
      send_edge(32'h8000_0001, 32'h7FFF_FFFE);
      send_edge(32'h0000_0001, 32'h0000_0001);
      send_edge(32'h7FFF_FFFE, 32'h8000_0001);

      // slow growth: mostly edges between stored vertices
      repeat (STAGE1_ITEMS) random_edge(5, 5, 15, 3);
      // fill the table; near the top some edges no longer fit
      while (sb.node_total < TB_DEPTH) random_edge(5, 2, 25, 58);
      // table full: stored pairs still pass, anything new is rejected
      repeat (STAGE3_ITEMS) random_edge(10, 10, 20, 20);

      @(negedge clock);
      req_ch.valid <= 1'b0;

      // drain, then allow for a stray response after a full table scan
      while (sb.pending_ids.size() != 0) @(posedge clock);
      repeat (TB_DEPTH + 16) @(posedge clock);

      if (sb.errors == 0 && sb.pending_ids.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/evr_pkg.sv
hdl/evr_channels.sv
hdl/evr_ctrl.sv
hdl/evr_datapath.sv
hdl/edge_vertex_relabel.sv
sim/tb_top.sv
